### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the touch sample checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSQC_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("touch sample check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSQC_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("touch sample check failed");

// Next-cycle implication that is also checked through reset.
`define TSQC_ASSERT_NEXT_ALWAYS(label, ck, ante, cons) \
  label: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("touch sample check failed");

`endif

### sv/tsqc_pkg.sv
// ---------------------------------------------------------------------------
// Touch sample qualify and calibrate package
// Widths, limits, register codes and the word types passed between parts.
// ---------------------------------------------------------------------------
`default_nettype none

package tsqc_pkg;

  localparam int WORD_W   = 16;   // raw converter word
  localparam int SHIFT_W  = 13;   // converter word after dropping three bits
  localparam int COORD_W  = 12;   // coordinate on the output
  localparam int PRESS_W  = 16;   // wrapped pressure
  localparam int OP_W     = 17;   // signed offset and span, two's complement
  localparam int DEN_W    = 16;   // magnitude of the span
  localparam int SIZE_W   = 13;   // display size up to 4096
  localparam int NUM_W    = DEN_W + SIZE_W - 1;  // magnitude of offset times size
  localparam int DIV_BITS = SIZE_W;              // quotient bits resolved
  localparam int LANE_LAT = DIV_BITS + 2;        // product, quotient bits, result

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [PRESS_W-1:0] PRESS_OFFSET = 16'd4095;
  localparam logic [PRESS_W-1:0] PRESS_MIN    = 16'd100;
  localparam logic [SHIFT_W-1:0] COORD_MIN    = 13'd100;
  localparam logic [SHIFT_W-1:0] COORD_MAX    = 13'd4095;

  localparam logic [WORD_W-1:0] RAW_MIN_RESET = 16'd200;
  localparam logic [WORD_W-1:0] RAW_MAX_RESET = 16'd3800;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ENABLE = 3'd4;

  typedef struct packed {
    logic [WORD_W-1:0] x_raw_min;
    logic [WORD_W-1:0] x_raw_max;
    logic [WORD_W-1:0] y_raw_min;
    logic [WORD_W-1:0] y_raw_max;
    logic              map_enable;
  } tsqc_cfg_t;

  // Operands of one coordinate: the pass-through value, v - min and max - min.
  typedef struct packed {
    logic [COORD_W-1:0] raw;
    logic [OP_W-1:0]    off;
    logic [OP_W-1:0]    span;
  } tsqc_lane_op_t;

  typedef struct packed {
    logic               ok;
    logic               map_en;
    logic [PRESS_W-1:0] pressure;
    tsqc_lane_op_t      lane_x;
    tsqc_lane_op_t      lane_y;
  } tsqc_item_t;

endpackage

`default_nettype wire

### sv/tsqc_if.sv
// ---------------------------------------------------------------------------
// Touch sample channel interfaces
// Valid/ready channels for raw samples, results and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface tsqc_in_if;
  logic                        valid;
  logic                        ready;
  logic [tsqc_pkg::WORD_W-1:0] x_word;
  logic [tsqc_pkg::WORD_W-1:0] y_word;
  logic [tsqc_pkg::WORD_W-1:0] z1_word;
  logic [tsqc_pkg::WORD_W-1:0] z2_word;

  modport source (output valid, x_word, y_word, z1_word, z2_word, input ready);
  modport sink   (input valid, x_word, y_word, z1_word, z2_word, output ready);
endinterface

interface tsqc_out_if;
  logic                         valid;
  logic                         ready;
  logic [tsqc_pkg::COORD_W-1:0] pos_x;
  logic [tsqc_pkg::COORD_W-1:0] pos_y;
  logic [tsqc_pkg::PRESS_W-1:0] pressure;
  logic                         touch_valid;

  modport source (output valid, pos_x, pos_y, pressure, touch_valid, input ready);
  modport sink   (input valid, pos_x, pos_y, pressure, touch_valid, output ready);
endinterface

interface tsqc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tsqc_pkg::CFG_IDX_W-1:0] index;
  logic [tsqc_pkg::WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/touch_sample_qualify_calibrate_core.sv
// An accepted input word passes the front-end register, the queue and the back end.
// Throughput: one word per cycle unless the output stalls; the thirteen-stage
// restoring divider in each coordinate lane takes a new operand every cycle.
// Reset: synchronous, active low; empties the queue and pipeline and loads the
// calibration registers with their defaults. There is no clearing pass.
// ---------------------------------------------------------------------------
// Touch sample qualify and calibrate core
// Qualifies resistive touch samples by pressure and range and maps the
// coordinates linearly onto the display when calibration is enabled.
// ---------------------------------------------------------------------------
`default_nettype none

module touch_sample_qualify_calibrate_core #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tsqc_in_if.sink     in_ch,
  tsqc_out_if.source  out_ch,
  tsqc_cfg_if.sink    cfg_ch
);

  localparam int LAT = tsqc_pkg::LANE_LAT;

  // Calibration registers. Writes are always taken; an index past the map
  // enable register is dropped.
  tsqc_pkg::tsqc_cfg_t cfg_r, cfg_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tsqc_pkg::REG_X_RAW_MIN:  cfg_nxt.x_raw_min  = cfg_ch.data;
        tsqc_pkg::REG_X_RAW_MAX:  cfg_nxt.x_raw_max  = cfg_ch.data;
        tsqc_pkg::REG_Y_RAW_MIN:  cfg_nxt.y_raw_min  = cfg_ch.data;
        tsqc_pkg::REG_Y_RAW_MAX:  cfg_nxt.y_raw_max  = cfg_ch.data;
        tsqc_pkg::REG_MAP_ENABLE: cfg_nxt.map_enable = cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_raw_min  <= tsqc_pkg::RAW_MIN_RESET;
      cfg_r.x_raw_max  <= tsqc_pkg::RAW_MAX_RESET;
      cfg_r.y_raw_min  <= tsqc_pkg::RAW_MIN_RESET;
      cfg_r.y_raw_max  <= tsqc_pkg::RAW_MAX_RESET;
      cfg_r.map_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: one register stage that shifts the raw words, forms the
  // wrapped pressure, applies the pressure and range checks and prepares the
  // signed offset and span of each coordinate from the current calibration.
  logic                 q_push, q_ready, q_pop, q_not_empty;
  tsqc_pkg::tsqc_item_t q_in_item, q_head;

  tsqc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_item  (q_in_item)
  );

  // The queue lets the front end keep taking words while the output is stalled,
  // until its four entries fill, and keeps the input ready off the output path.
  tsqc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_item  (q_head),
    .not_empty  (q_not_empty)
  );

  // Back end: a lock-step pipeline of LAT stages. Every stage moves together
  // whenever the last stage, which is the output register, is empty or is
  // being taken. The two mapping lanes run alongside the valid, qualify and
  // pressure delay line below.
  logic                         adv;
  logic                         vld_r  [0:LAT-1];
  logic                         ok_r   [0:LAT-1];
  logic [tsqc_pkg::PRESS_W-1:0] pres_r [0:LAT-1];
  logic [tsqc_pkg::COORD_W-1:0] map_x, map_y;

  assign adv   = !vld_r[LAT-1] || out_ch.ready;
  assign q_pop = adv && q_not_empty;

  tsqc_map_lane #(.SIZE(SCREEN_WIDTH)) u_lane_x (
    .clk    (clk),
    .en     (adv),
    .op_in  (q_head.lane_x),
    .map_en (q_head.map_en),
    .coord  (map_x)
  );

  tsqc_map_lane #(.SIZE(SCREEN_HEIGHT)) u_lane_y (
    .clk    (clk),
    .en     (adv),
    .op_in  (q_head.lane_y),
    .map_en (q_head.map_en),
    .coord  (map_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= q_not_empty;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok_r[0]   <= q_head.ok;
      pres_r[0] <= q_head.pressure;
      for (int i = 1; i < LAT; i++) begin
        ok_r[i]   <= ok_r[i-1];
        pres_r[i] <= pres_r[i-1];
      end
    end
  end

  // A rejected sample shows all fields as zero.
  assign out_ch.valid       = vld_r[LAT-1];
  assign out_ch.touch_valid = ok_r[LAT-1];
  assign out_ch.pos_x       = ok_r[LAT-1] ? map_x : '0;
  assign out_ch.pos_y       = ok_r[LAT-1] ? map_y : '0;
  assign out_ch.pressure    = ok_r[LAT-1] ? pres_r[LAT-1] : '0;

endmodule

`default_nettype wire

### sv/tsqc_front.sv
// ---------------------------------------------------------------------------
// Touch sample front end
// Accepts raw words, qualifies them and prepares the mapping operands.
// ---------------------------------------------------------------------------
`default_nettype none

module tsqc_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  tsqc_in_if.sink                   in_ch,
  input  wire tsqc_pkg::tsqc_cfg_t  cfg,
  input  wire logic                 q_ready,
  output logic                      q_push,
  output tsqc_pkg::tsqc_item_t      q_item
);

  logic                           fr_valid_r, fr_valid_nxt;
  tsqc_pkg::tsqc_item_t           fr_item_r, fr_item_nxt;
  logic                           accept;
  logic [tsqc_pkg::SHIFT_W-1:0]   x_s, y_s, z1_s, z2_s;
  logic [tsqc_pkg::PRESS_W-1:0]   press;

  assign in_ch.ready = !fr_valid_r || q_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = fr_valid_r && q_ready;
  assign q_item      = fr_item_r;

  always_comb begin
    x_s  = in_ch.x_word[tsqc_pkg::WORD_W-1:3];
    y_s  = in_ch.y_word[tsqc_pkg::WORD_W-1:3];
    z1_s = in_ch.z1_word[tsqc_pkg::WORD_W-1:3];
    z2_s = in_ch.z2_word[tsqc_pkg::WORD_W-1:3];
    press = {3'b000, z1_s} + tsqc_pkg::PRESS_OFFSET - {3'b000, z2_s};

    fr_item_nxt.ok = (press >= tsqc_pkg::PRESS_MIN)
                  && (x_s >= tsqc_pkg::COORD_MIN) && (x_s <= tsqc_pkg::COORD_MAX)
                  && (y_s >= tsqc_pkg::COORD_MIN) && (y_s <= tsqc_pkg::COORD_MAX);
    fr_item_nxt.map_en   = cfg.map_enable;
    fr_item_nxt.pressure = press;

    // Offsets and spans are formed in 17 bits and read as two's complement.
    fr_item_nxt.lane_x.raw  = x_s[tsqc_pkg::COORD_W-1:0];
    fr_item_nxt.lane_x.off  = {4'b0000, x_s} - {1'b0, cfg.x_raw_min};
    fr_item_nxt.lane_x.span = {1'b0, cfg.x_raw_max} - {1'b0, cfg.x_raw_min};
    fr_item_nxt.lane_y.raw  = y_s[tsqc_pkg::COORD_W-1:0];
    fr_item_nxt.lane_y.off  = {4'b0000, y_s} - {1'b0, cfg.y_raw_min};
    fr_item_nxt.lane_y.span = {1'b0, cfg.y_raw_max} - {1'b0, cfg.y_raw_min};
  end

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (q_push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r <= fr_item_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/tsqc_queue.sv
// ---------------------------------------------------------------------------
// Touch sample queue
// Short first-in first-out buffer between the front end and the mapper.
// ---------------------------------------------------------------------------
`default_nettype none

module tsqc_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire tsqc_pkg::tsqc_item_t  push_item,
  output logic                       push_ready,
  input  wire logic                  pop,
  output tsqc_pkg::tsqc_item_t       head_item,
  output logic                       not_empty
);

  tsqc_pkg::tsqc_item_t          mem_r [0:tsqc_pkg::QUEUE_DEPTH-1];
  logic [tsqc_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [tsqc_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [tsqc_pkg::QCNT_W-1:0]   count_r, count_nxt;

  assign push_ready = count_r != tsqc_pkg::QCNT_W'(tsqc_pkg::QUEUE_DEPTH);
  assign not_empty  = count_r != '0;
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

### sv/tsqc_map_lane.sv
// ---------------------------------------------------------------------------
// Touch sample mapping lane
// Scales one coordinate onto the display with a pipelined restoring divider.
// ---------------------------------------------------------------------------
`default_nettype none

module tsqc_map_lane #(
  parameter int SIZE = 320
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire tsqc_pkg::tsqc_lane_op_t        op_in,
  input  wire logic                           map_en,
  output logic [tsqc_pkg::COORD_W-1:0]        coord
);

  localparam int NW = tsqc_pkg::NUM_W;
  localparam int DW = tsqc_pkg::DEN_W;
  localparam int SW = tsqc_pkg::SIZE_W;
  localparam int QB = tsqc_pkg::DIV_BITS;
  localparam int CW = tsqc_pkg::COORD_W;
  localparam int OW = tsqc_pkg::OP_W;
  localparam logic [SW-1:0] SizeVal = SW'(SIZE);
  localparam logic [SW-1:0] SizeTop = SW'(SIZE - 1);

  // Stage 0 holds the scaled offset; stage k resolves quotient bit QB-k.
  logic [NW-1:0] rem_r  [0:QB];
  logic [DW-1:0] den_r  [0:QB];
  logic [QB-1:0] quo_r  [0:QB];
  logic          zero_r [0:QB];
  logic          ovf_r  [0:QB];
  logic          men_r  [0:QB];
  logic [CW-1:0] raw_r  [0:QB];

  logic [NW-1:0] rem_nxt [0:QB];
  logic [QB-1:0] quo_nxt [0:QB];
  logic          ovf_nxt [0:QB];

  logic [OW-1:0]    off_abs, span_abs;
  logic [DW+SW-1:0] prod;
  logic             zero_nxt;
  logic [SW-1:0]    sel;
  logic [CW-1:0]    coord_r, coord_nxt;

  // A quotient whose sign would be negative clamps to zero, as does an empty span.
  always_comb begin
    off_abs  = op_in.off[OW-1]  ? (~op_in.off + 1'b1)  : op_in.off;
    span_abs = op_in.span[OW-1] ? (~op_in.span + 1'b1) : op_in.span;
    prod     = {{SW{1'b0}}, off_abs[DW-1:0]} * {{DW{1'b0}}, SizeVal};
    zero_nxt = (op_in.span == '0) || (op_in.off[OW-1] != op_in.span[OW-1]);
  end

  assign rem_nxt[0] = prod[NW-1:0];
  assign quo_nxt[0] = '0;
  assign ovf_nxt[0] = 1'b0;

  for (genvar k = 1; k <= QB; k++) begin : g_div
    localparam int B = QB - k;
    logic [NW-1:0] trial;
    logic          take;

    assign trial = {{(NW-DW){1'b0}}, den_r[k-1]} << B;
    assign take  = rem_r[k-1] >= trial;
    assign rem_nxt[k] = take ? rem_r[k-1] - trial : rem_r[k-1];
    assign quo_nxt[k] = quo_r[k-1] | (QB'(take) << B);
    if (k == 1) begin : g_ovf
      // A quotient of 2**QB or more clamps to the top pixel unless the zero clamp holds.
      assign ovf_nxt[k] = {1'b0, rem_r[0]} >= {den_r[0], {QB{1'b0}}};
    end else begin : g_keep
      assign ovf_nxt[k] = ovf_r[k-1];
    end
  end

  always_comb begin
    if (zero_r[QB]) begin
      sel = '0;
    end else if (ovf_r[QB] || (quo_r[QB] >= SizeVal)) begin
      sel = SizeTop;
    end else begin
      sel = quo_r[QB];
    end
    coord_nxt = men_r[QB] ? sel[CW-1:0] : raw_r[QB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= rem_nxt[0];
      den_r[0]  <= span_abs[DW-1:0];
      quo_r[0]  <= quo_nxt[0];
      zero_r[0] <= zero_nxt;
      ovf_r[0]  <= ovf_nxt[0];
      men_r[0]  <= map_en;
      raw_r[0]  <= op_in.raw;
      for (int k = 1; k <= QB; k++) begin
        rem_r[k]  <= rem_nxt[k];
        den_r[k]  <= den_r[k-1];
        quo_r[k]  <= quo_nxt[k];
        zero_r[k] <= zero_r[k-1];
        ovf_r[k]  <= ovf_nxt[k];
        men_r[k]  <= men_r[k-1];
        raw_r[k]  <= raw_r[k-1];
      end
      coord_r <= coord_nxt;
    end
  end

  assign coord = coord_r;

endmodule

`default_nettype wire

### sv/tsqc_checker.sv
// ---------------------------------------------------------------------------
// Touch sample checker
// Port-level assertions on the result channel of the touch sample core.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tsqc_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [tsqc_pkg::COORD_W-1:0] out_pos_x,
  input wire logic [tsqc_pkg::COORD_W-1:0] out_pos_y,
  input wire logic [tsqc_pkg::PRESS_W-1:0] out_pressure,
  input wire logic                         out_touch_valid
);

  // A stalled result word holds.
  `TSQC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_pressure) && $stable(out_touch_valid))

  // A rejected sample carries no coordinate or pressure.
  `TSQC_ASSERT_NOW(a_reject_zero, clk, rst_n, out_valid && !out_touch_valid, (out_pos_x == '0) && (out_pos_y == '0) && (out_pressure == '0))

  // A qualified sample has passed the pressure threshold.
  `TSQC_ASSERT_NOW(a_touch_press, clk, rst_n, out_valid && out_touch_valid, out_pressure >= tsqc_pkg::PRESS_MIN)

  // Reset empties the pipeline, so no result is offered after it.
  `TSQC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind touch_sample_qualify_calibrate_core tsqc_checker u_tsqc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_pos_x       (out_ch.pos_x),
  .out_pos_y       (out_ch.pos_y),
  .out_pressure    (out_ch.pressure),
  .out_touch_valid (out_ch.touch_valid)
);

`default_nettype wire

### sim/testbench.sv
// ---------------------------------------------------------------------------
// Touch sample qualify and calibrate testbench
// Drives raw converter words through the core and checks each result word
// against a predictor of the qualification and calibration rules. A
// directed table comes first, then random words under changing calibration.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int WORD_W    = tsqc_pkg::WORD_W;
  localparam int SHIFT_W   = tsqc_pkg::SHIFT_W;
  localparam int COORD_W   = tsqc_pkg::COORD_W;
  localparam int PRESS_W   = tsqc_pkg::PRESS_W;
  localparam int CFG_IDX_W = tsqc_pkg::CFG_IDX_W;

  localparam logic [PRESS_W-1:0] PRESS_OFFSET  = tsqc_pkg::PRESS_OFFSET;
  localparam logic [PRESS_W-1:0] PRESS_MIN     = tsqc_pkg::PRESS_MIN;
  localparam logic [SHIFT_W-1:0] COORD_MIN     = tsqc_pkg::COORD_MIN;
  localparam logic [SHIFT_W-1:0] COORD_MAX     = tsqc_pkg::COORD_MAX;
  localparam logic [WORD_W-1:0]  RAW_MIN_RESET = tsqc_pkg::RAW_MIN_RESET;
  localparam logic [WORD_W-1:0]  RAW_MAX_RESET = tsqc_pkg::RAW_MAX_RESET;

  localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MIN  = tsqc_pkg::REG_X_RAW_MIN;
  localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MAX  = tsqc_pkg::REG_X_RAW_MAX;
  localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MIN  = tsqc_pkg::REG_Y_RAW_MIN;
  localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MAX  = tsqc_pkg::REG_Y_RAW_MAX;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ENABLE = tsqc_pkg::REG_MAP_ENABLE;

  localparam int DISP_W        = 320;
  localparam int DISP_H        = 240;
  localparam int PIPE_LAT      = 16;          // input word to result word
  localparam int SETTLE_CYCLES = 2 * PIPE_LAT;
  localparam int QUIET_LIMIT   = 2000;        // cycles with no word moved
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 75;
  localparam int PLAN_ROWS     = 35;
  localparam int IDLE_PCT      = 33;

  // Register indexes past the end of the list; writes to them must not land.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_MAP_ENABLE + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  typedef struct packed {
    logic [WORD_W-1:0] x_word;
    logic [WORD_W-1:0] y_word;
    logic [WORD_W-1:0] z1_word;
    logic [WORD_W-1:0] z2_word;
  } touch_sample_t;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [PRESS_W-1:0] pressure;
    logic               touch_valid;
  } touch_fix_t;

  // A table row either sends a word whose result is typed in, sends a word
  // left to the predictor, or writes a calibration register.
  typedef enum logic [1:0] {ROW_TYPED, ROW_PREDICT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    touch_sample_t          smp;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [WORD_W-1:0]      reg_data;
    touch_fix_t             fix;
  } plan_row_t;

  typedef struct packed {
    logic       quoted;
    touch_fix_t fix;
  } table_fix_t;

  logic clk = 1'b0;
  logic rst_n;

  tsqc_in_if  in_ch();
  tsqc_out_if out_ch();
  tsqc_cfg_if cfg_ch();

  touch_sample_qualify_calibrate_core #(
    .SCREEN_WIDTH  (DISP_W),
    .SCREEN_HEIGHT (DISP_H)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our copy of the calibration registers, updated on each accepted write.
  logic [WORD_W-1:0] cal_x_min;
  logic [WORD_W-1:0] cal_x_max;
  logic [WORD_W-1:0] cal_y_min;
  logic [WORD_W-1:0] cal_y_max;
  logic              cal_map_en;

  touch_fix_t pending_fix_q [$];   // expected result words, oldest first
  table_fix_t table_fix_q [$];     // one entry per offered word, in order
  plan_row_t  plan [PLAN_ROWS];

  bit steady_phase = 1'b0;         // no idling on either side while set
  int fault_count  = 0;
  int samples_taken = 0;
  int fixes_seen   = 0;
  int touches_seen = 0;
  int reg_writes   = 0;
  int quiet_cycles = 0;

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  // Linear map of one coordinate onto the display. The quotient is signed
  // and truncates toward zero, so a reversed span mirrors the axis; the
  // result is then clamped into the display. A zero span maps to pixel 0.
  function automatic logic [COORD_W-1:0] scale_axis(input int v, input int lo,
                                                    input int hi, input int size);
    longint span;
    longint m;
    span = longint'(hi) - longint'(lo);
    if (span == 0) return '0;
    m = ((longint'(v) - longint'(lo)) * longint'(size)) / span;
    if (m >= size) m = size - 1;
    if (m < 0) m = 0;
    return COORD_W'(m);
  endfunction

  function automatic touch_fix_t qualify_touch(input touch_sample_t s);
    logic [SHIFT_W-1:0] xs;
    logic [SHIFT_W-1:0] ys;
    logic [SHIFT_W-1:0] z1s;
    logic [SHIFT_W-1:0] z2s;
    logic [PRESS_W-1:0] press;
    touch_fix_t         r;
    // The three low bits of every converter word carry no information.
    xs  = s.x_word[WORD_W-1:3];
    ys  = s.y_word[WORD_W-1:3];
    z1s = s.z1_word[WORD_W-1:3];
    z2s = s.z2_word[WORD_W-1:3];
    // Pressure wraps at 16 bits, so a large z2 gives a large pressure.
    press = PRESS_W'(z1s) + PRESS_OFFSET - PRESS_W'(z2s);
    r = '0;
    if (press < PRESS_MIN || xs < COORD_MIN || ys < COORD_MIN ||
        xs > COORD_MAX || ys > COORD_MAX) return r;
    if (cal_map_en) begin
      r.pos_x = scale_axis(xs, cal_x_min, cal_x_max, DISP_W);
      r.pos_y = scale_axis(ys, cal_y_min, cal_y_max, DISP_H);
    end else begin
      r.pos_x = xs[COORD_W-1:0];
      r.pos_y = ys[COORD_W-1:0];
    end
    r.pressure    = press;
    r.touch_valid = 1'b1;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Table rows and random words
  // -------------------------------------------------------------------------

  function automatic plan_row_t typed_row(input logic [WORD_W-1:0] x, y, z1, z2,
                                          input int px, py, pr, input logic tv);
    plan_row_t r;
    r = '0;
    r.kind = ROW_TYPED;
    r.smp  = '{x, y, z1, z2};
    r.fix  = '{COORD_W'(px), COORD_W'(py), PRESS_W'(pr), tv};
    return r;
  endfunction

  function automatic plan_row_t predict_row(input logic [WORD_W-1:0] x, y, z1, z2);
    plan_row_t r;
    r = '0;
    r.kind = ROW_PREDICT;
    r.smp  = '{x, y, z1, z2};
    return r;
  endfunction

  function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [WORD_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.kind     = ROW_WRITE;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  // Mostly touches with in-range coordinates and random pressure, then words
  // sitting on the range and pressure thresholds, then plain noise.
  function automatic touch_sample_t random_touch_sample();
    int                 mode;
    logic [SHIFT_W-1:0] xs;
    logic [SHIFT_W-1:0] ys;
    logic [SHIFT_W-1:0] z1s;
    logic [SHIFT_W-1:0] z2s;
    touch_sample_t      s;
    mode = $urandom_range(0, 99);
    s.x_word  = WORD_W'($urandom);
    s.y_word  = WORD_W'($urandom);
    s.z1_word = WORD_W'($urandom);
    s.z2_word = WORD_W'($urandom);
    if (mode < 70) begin
      xs = SHIFT_W'($urandom_range(100, 4095));
      ys = SHIFT_W'($urandom_range(100, 4095));
      s.x_word = {xs, 3'($urandom)};
      s.y_word = {ys, 3'($urandom)};
    end else if (mode < 85) begin
      xs = $urandom_range(0, 1) ? SHIFT_W'($urandom_range(98, 101))
                                : SHIFT_W'($urandom_range(4094, 4097));
      ys = $urandom_range(0, 1) ? SHIFT_W'($urandom_range(98, 101))
                                : SHIFT_W'($urandom_range(4094, 4097));
      // Pressure lands within a couple of counts of the threshold.
      z1s = SHIFT_W'($urandom_range(0, 4000));
      z2s = SHIFT_W'(int'(z1s) + 4095 - int'($urandom_range(98, 102)));
      s.x_word  = {xs, 3'($urandom)};
      s.y_word  = {ys, 3'($urandom)};
      s.z1_word = {z1s, 3'($urandom)};
      s.z2_word = {z2s, 3'($urandom)};
    end
    return s;
  endfunction

  // Calibration bounds favor the useful range but hit both ends of the field.
  function automatic logic [WORD_W-1:0] pick_raw_bound();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return WORD_W'($urandom);
      default: return WORD_W'($urandom_range(100, 4095));
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Channel drivers
  // -------------------------------------------------------------------------

  // Offers one sample word and returns at the edge where it is taken. The
  // valid line stays high on return so back-to-back words need no gap.
  task automatic offer_sample(input touch_sample_t s, input logic quoted,
                              input touch_fix_t fix);
    while (!steady_phase && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    table_fix_q.push_back('{quoted, fix});
    in_ch.valid   <= 1'b1;
    in_ch.x_word  <= s.x_word;
    in_ch.y_word  <= s.y_word;
    in_ch.z1_word <= s.z1_word;
    in_ch.z2_word <= s.z2_word;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops offering words and waits until every expected result has arrived.
  // Each word yields exactly one result, so the core is then empty.
  task automatic wait_for_fixes();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_fix_q.size() != 0);
  endtask

  // Writes one register; the extra edge keeps the next raise of valid in a
  // later time step than this lowering.
  task automatic write_cal_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [WORD_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // The result side stalls at random except during the steady phase.
  always @(posedge clk) begin
    out_ch.ready <= steady_phase || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // -------------------------------------------------------------------------
  // Monitor and scoreboard
  // -------------------------------------------------------------------------

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      fault_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    touch_sample_t smp;
    touch_fix_t    want;
    table_fix_t    entry;
    if (!rst_n) begin
      cal_x_min  = RAW_MIN_RESET;
      cal_x_max  = RAW_MAX_RESET;
      cal_y_min  = RAW_MIN_RESET;
      cal_y_max  = RAW_MAX_RESET;
      cal_map_en = 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        reg_writes++;
        case (cfg_ch.index)
          REG_X_RAW_MIN:  cal_x_min  = cfg_ch.data;
          REG_X_RAW_MAX:  cal_x_max  = cfg_ch.data;
          REG_Y_RAW_MIN:  cal_y_min  = cfg_ch.data;
          REG_Y_RAW_MAX:  cal_y_max  = cfg_ch.data;
          REG_MAP_ENABLE: cal_map_en = cfg_ch.data[0];
          default: ;
        endcase
      end
      // An accepted sample word queues its expected result: the typed-in one
      // from the table where there is one, otherwise the predicted one.
      if (in_ch.valid && in_ch.ready) begin
        smp = '{in_ch.x_word, in_ch.y_word, in_ch.z1_word, in_ch.z2_word};
        entry = '0;
        if (table_fix_q.size() != 0) entry = table_fix_q.pop_front();
        want = entry.quoted ? entry.fix : qualify_touch(smp);
        pending_fix_q.push_back(want);
        samples_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        fixes_seen++;
        if (out_ch.touch_valid === 1'b1) touches_seen++;
        if (pending_fix_q.size() == 0) begin
          fault_count++;
          $display("%0t: result word with nothing expected, got x %0d y %0d p %0d v %0b",
                   $time, out_ch.pos_x, out_ch.pos_y, out_ch.pressure,
                   out_ch.touch_valid);
        end else begin
          want = pending_fix_q.pop_front();
          compare_field("pos_x", want.pos_x, out_ch.pos_x);
          compare_field("pos_y", want.pos_y, out_ch.pos_y);
          compare_field("pressure", want.pressure, out_ch.pressure);
          compare_field("touch_valid", want.touch_valid, out_ch.touch_valid);
        end
      end
    end
  end

  // Ends the run if no word moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("[touch_sample_qualify_calibrate_core] ERROR");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.x_word  = '0;
    in_ch.y_word  = '0;
    in_ch.z1_word = '0;
    in_ch.z2_word = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_X_RAW_MIN;
    cfg_ch.data   = '0;

    plan = '{
      // Reset calibration, mapping off: coordinates pass through shifted.
      typed_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 1'b0),
      typed_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 1'b0),
      typed_row(16'd800, 16'd800, 16'd0, 16'd0, 100, 100, 4095, 1'b1),
      typed_row(16'd799, 16'd800, 16'd0, 16'd0, 0, 0, 0, 1'b0),
      typed_row(16'd800, 16'd799, 16'd0, 16'd0, 0, 0, 0, 1'b0),
      typed_row(16'd32767, 16'd32767, 16'd32767, 16'd0, 4095, 4095, 8190, 1'b1),
      typed_row(16'd32768, 16'd32767, 16'd0, 16'd0, 0, 0, 0, 1'b0),
      typed_row(16'd32767, 16'd32768, 16'd0, 16'd0, 0, 0, 0, 1'b0),
      // Pressure exactly at the threshold, one below, and wrapped around.
      typed_row(16'd800, 16'd800, 16'd0, 16'd31960, 100, 100, 100, 1'b1),
      typed_row(16'd800, 16'd800, 16'd0, 16'd31968, 0, 0, 0, 1'b0),
      typed_row(16'd800, 16'd800, 16'd0, 16'hFFFF, 100, 100, 61440, 1'b1),
      typed_row(16'd800, 16'd800, 16'hFFFF, 16'd0, 100, 100, 12286, 1'b1),
      typed_row(16'd4007, 16'd4000, 16'd7, 16'd7, 500, 500, 4095, 1'b1),
      // Mapping on with the reset bounds; upper data bits are ignored.
      write_row(REG_MAP_ENABLE, 16'hFFFF),
      typed_row(16'd1600, 16'd1600, 16'd0, 16'd0, 0, 0, 4095, 1'b1),
      typed_row(16'd30400, 16'd30400, 16'd0, 16'd0, 319, 239, 4095, 1'b1),
      typed_row(16'd800, 16'd800, 16'd0, 16'd0, 0, 0, 4095, 1'b1),
      typed_row(16'd32767, 16'd32767, 16'd0, 16'd0, 319, 239, 4095, 1'b1),
      predict_row(16'd16000, 16'd16000, 16'd0, 16'd0),
      predict_row(16'd1607, 16'd12345, 16'd9999, 16'd1234),
      // Zero span on x.
      write_row(REG_X_RAW_MIN, 16'd1000),
      write_row(REG_X_RAW_MAX, 16'd1000),
      predict_row(16'd8000, 16'd8000, 16'd0, 16'd0),
      // Reversed span on y mirrors the axis.
      write_row(REG_Y_RAW_MIN, 16'd3800),
      write_row(REG_Y_RAW_MAX, 16'd200),
      predict_row(16'd8000, 16'd4000, 16'd0, 16'd0),
      predict_row(16'd800, 16'd32767, 16'd4321, 16'd2222),
      // Widest x span, then writes to indexes past the register list.
      write_row(REG_X_RAW_MIN, 16'h0000),
      write_row(REG_X_RAW_MAX, 16'hFFFF),
      write_row(REG_SPARE_LO, 16'd1234),
      write_row(REG_SPARE_HI, 16'd1234),
      predict_row(16'd16000, 16'd16000, 16'd100, 16'd50),
      predict_row(16'd32767, 16'd1600, 16'd0, 16'd0),
      // Only bit zero of the enable write counts.
      write_row(REG_MAP_ENABLE, 16'hFFFE),
      typed_row(16'd16000, 16'd8000, 16'd0, 16'd0, 2000, 1000, 4095, 1'b1)
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_WRITE: begin
          wait_for_fixes();
          write_cal_reg(plan[i].reg_idx, plan[i].reg_data);
        end
        ROW_TYPED:   offer_sample(plan[i].smp, 1'b1, plan[i].fix);
        default:     offer_sample(plan[i].smp, 1'b0, '0);
      endcase
    end

    // Random phases, each under its own calibration. The third one runs
    // without idling on either side.
    for (int phase = 0; phase < PHASES; phase++) begin
      logic [WORD_W-1:0] lo_x;
      logic [WORD_W-1:0] lo_y;
      logic [WORD_W-1:0] en_word;
      wait_for_fixes();
      steady_phase = (phase == 2);
      lo_x = pick_raw_bound();
      lo_y = pick_raw_bound();
      write_cal_reg(REG_X_RAW_MIN, lo_x);
      write_cal_reg(REG_X_RAW_MAX, ($urandom_range(0, 7) == 0) ? lo_x : pick_raw_bound());
      write_cal_reg(REG_Y_RAW_MIN, lo_y);
      write_cal_reg(REG_Y_RAW_MAX, ($urandom_range(0, 7) == 0) ? lo_y : pick_raw_bound());
      en_word = WORD_W'($urandom);
      en_word[0] = ($urandom_range(0, 3) != 0);
      write_cal_reg(REG_MAP_ENABLE, en_word);
      if ($urandom_range(0, 2) == 0)
        write_cal_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                      WORD_W'($urandom));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Now and then the sender holds off until the core has drained.
        if ($urandom_range(0, 39) == 0) wait_for_fixes();
        offer_sample(random_touch_sample(), 1'b0, '0);
      end
    end
    steady_phase = 1'b0;

    wait_for_fixes();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d sample words and %0d result words, %0d of them valid touches,",
             samples_taken, fixes_seen, touches_seen);
    $display("under %0d register writes across %0d calibration phases.",
             reg_writes, PHASES + 1);
    if (fault_count == 0) begin
      $display("[touch_sample_qualify_calibrate_core] OK");
    end else begin
      $display("[touch_sample_qualify_calibrate_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+sv
sv/tsqc_pkg.sv
sv/tsqc_if.sv
sv/tsqc_front.sv
sv/tsqc_queue.sv
sv/tsqc_map_lane.sv
sv/touch_sample_qualify_calibrate_core.sv
sv/tsqc_checker.sv
sim/testbench.sv
